// ----- hw/rtl/phmt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phmt_pkg
// Shared types and constants of the dual-role key engine.
// ----------------------------------------------------------------------------
package phmt_pkg;

  localparam int KEY_W     = 16;
  localparam int TIME_W    = 16;
  localparam int LAYER_W   = 32;
  localparam int ENTRY_W   = 48;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 48;
  localparam int MAX_SLOTS = 5;
  localparam logic [TIME_W-1:0] TAP_WINDOW_RST = 16'd150;

  typedef enum logic [CFG_AW-1:0] {
    REG_TAP_WINDOW  = 3'd0,
    REG_ENTRY_ZERO  = 3'd1,
    REG_ENTRY_ONE   = 3'd2,
    REG_ENTRY_TWO   = 3'd3,
    REG_ENTRY_THREE = 3'd4,
    REG_ENTRY_FOUR  = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    ACT_NONE       = 2'd0,
    ACT_REGISTER   = 2'd1,
    ACT_UNREGISTER = 2'd2,
    ACT_TAP        = 2'd3
  } action_e;

  // Key event traveling along the cell row
  typedef struct packed {
    logic              valid;
    logic              press;
    logic              lsw;      // last layer update since last key event changed the layer
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] now;
    logic              hit;
    logic              do_tap;
    logic [KEY_W-1:0]  mod;
    logic [KEY_W-1:0]  tap;
  } tok_t;

endpackage

// ----- hw/rtl/phmt_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phmt_in_if
// Key event / layer update channel.
// ----------------------------------------------------------------------------
interface phmt_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] keycode;
  logic        pressed;
  logic [15:0] now_ms;
  logic [31:0] layer_state;

  modport source (output valid, op, keycode, pressed, now_ms, layer_state, input ready);
  modport sink   (input valid, op, keycode, pressed, now_ms, layer_state, output ready);
endinterface

// ----- hw/rtl/phmt_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phmt_out_if
// Result channel.
// ----------------------------------------------------------------------------
interface phmt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] code;
  logic        handled;
  logic        last;

  modport source (output valid, action, code, handled, last, input ready);
  modport sink   (input valid, action, code, handled, last, output ready);
endinterface

// ----- hw/rtl/phmt_cfg_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phmt_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
interface phmt_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  addr;
  logic [47:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

// ----- hw/rtl/pre_hold_mod_tap_engine_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pre_hold_mod_tap_engine_top
// Dual-role key engine: table of trigger keys with modifier and tap codes.
// ----------------------------------------------------------------------------
// A key event walks the row of NUM_ENTRIES entry cells, one cell per cycle,
// and its first result is registered from the output of the last cell; a
// release that taps gives a second result in the cycle after the first is
// taken. A layer update answers in the cycle after its transfer. One item is
// in flight at a time: the next input transfer is taken the cycle after the
// last result transfer. Register writes are taken every cycle and must only
// be issued while the engine is idle.
module pre_hold_mod_tap_engine_top
  import phmt_pkg::*;
#(
  parameter int NUM_ENTRIES = 5
) (
  input  logic clk,
  input  logic rst_n,
  phmt_in_if.sink    in_ch,
  phmt_out_if.source out_ch,
  phmt_cfg_if.sink   cfg_ch
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_OUT1, S_OUT2} state_t;

  state_t             state_r;
  logic [TIME_W-1:0]  tap_window_r;
  logic               lsw_r;
  logic [LAYER_W-1:0] prev_layer_r;
  logic               out_valid_r;
  action_e            action_r;
  logic [KEY_W-1:0]   code_r;
  logic               handled_r;
  logic               last_r;
  logic               tap_pend_r;
  logic [KEY_W-1:0]   tap_code_r;

  tok_t chain [NUM_ENTRIES+1];
  tok_t tail;
  logic in_xfer, out_xfer, cfg_xfer;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_xfer      = in_ch.valid & in_ch.ready;
  assign out_xfer     = out_ch.valid & out_ch.ready;
  assign cfg_xfer     = cfg_ch.valid;

  always_comb begin
    chain[0]        = '0;
    chain[0].valid  = in_xfer & ~in_ch.op;
    chain[0].press  = in_ch.pressed;
    chain[0].lsw    = lsw_r;
    chain[0].key    = in_ch.keycode;
    chain[0].now    = in_ch.now_ms;
  end

  for (genvar i = 0; i < NUM_ENTRIES; i++) begin : g_cell
    phmt_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .entry_we    (cfg_xfer && cfg_ch.addr == CFG_AW'(int'(REG_ENTRY_ZERO) + i)),
      .entry_wdata (cfg_ch.data[ENTRY_W-1:0]),
      .tap_window  (tap_window_r),
      .tok_i       (chain[i]),
      .tok_o       (chain[i+1])
    );
  end

  assign tail = chain[NUM_ENTRIES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_window_r <= TAP_WINDOW_RST;
    end else if (cfg_xfer && cfg_ch.addr == REG_TAP_WINDOW) begin
      tap_window_r <= cfg_ch.data[TIME_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      lsw_r        <= 1'b0;
      prev_layer_r <= '0;
      out_valid_r  <= 1'b0;
      action_r     <= ACT_NONE;
      code_r       <= '0;
      handled_r    <= 1'b0;
      last_r       <= 1'b0;
      tap_pend_r   <= 1'b0;
      tap_code_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            if (in_ch.op) begin
              lsw_r        <= (in_ch.layer_state != prev_layer_r);
              prev_layer_r <= in_ch.layer_state;
              out_valid_r  <= 1'b1;
              action_r     <= ACT_NONE;
              code_r       <= '0;
              handled_r    <= 1'b0;
              last_r       <= 1'b1;
              tap_pend_r   <= 1'b0;
              state_r      <= S_OUT1;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (tail.valid) begin
            lsw_r       <= 1'b0;
            out_valid_r <= 1'b1;
            tap_code_r  <= tail.tap;
            state_r     <= S_OUT1;
            if (!tail.hit) begin
              action_r   <= ACT_NONE;
              code_r     <= '0;
              handled_r  <= 1'b0;
              last_r     <= 1'b1;
              tap_pend_r <= 1'b0;
            end else if (tail.press) begin
              action_r   <= ACT_REGISTER;
              code_r     <= tail.mod;
              handled_r  <= 1'b1;
              last_r     <= 1'b1;
              tap_pend_r <= 1'b0;
            end else begin
              action_r   <= ACT_UNREGISTER;
              code_r     <= tail.mod;
              handled_r  <= 1'b1;
              last_r     <= ~tail.do_tap;
              tap_pend_r <= tail.do_tap;
            end
          end
        end
        S_OUT1: begin
          if (out_xfer) begin
            if (tap_pend_r) begin
              action_r   <= ACT_TAP;
              code_r     <= tap_code_r;
              last_r     <= 1'b1;
              tap_pend_r <= 1'b0;
              state_r    <= S_OUT2;
            end else begin
              out_valid_r <= 1'b0;
              state_r     <= S_IDLE;
            end
          end
        end
        S_OUT2: begin
          if (out_xfer) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          out_valid_r <= 1'b0;
          state_r     <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.action  = action_r;
  assign out_ch.code    = code_r;
  assign out_ch.handled = handled_r;
  assign out_ch.last    = last_r;

endmodule

// ----- hw/rtl/phmt_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phmt_cell
// One table entry with its hold state; checks the passing key event and
// hands it on to the next cell through its output register.
// ----------------------------------------------------------------------------
module phmt_cell
  import phmt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               entry_we,
  input  logic [ENTRY_W-1:0] entry_wdata,
  input  logic [TIME_W-1:0]  tap_window,
  input  tok_t               tok_i,
  output tok_t               tok_o
);

  logic [ENTRY_W-1:0] entry_r;
  logic [TIME_W-1:0]  time_r, time_nxt;
  logic               int_r, int_nxt;
  logic               held_r, held_nxt;
  tok_t               tok_r, tok_nxt;

  logic [TIME_W-1:0]  elapsed;
  logic [KEY_W-1:0]   trig;
  logic               int_scan;
  logic               match;

  assign elapsed  = tok_i.now - time_r;
  assign trig     = entry_r[47:32];
  assign int_scan = int_r | (held_r & (tok_i.press | (elapsed > tap_window)));
  assign match    = tok_i.valid & ~tok_i.hit & (trig != '0) & (trig == tok_i.key);

  always_comb begin
    time_nxt = time_r;
    int_nxt  = int_r;
    held_nxt = held_r;
    tok_nxt  = tok_i;
    if (tok_i.valid) begin
      int_nxt = int_scan;
    end
    if (match) begin
      tok_nxt.hit    = 1'b1;
      tok_nxt.mod    = entry_r[31:16];
      tok_nxt.tap    = entry_r[15:0];
      tok_nxt.do_tap = 1'b0;
      if (tok_i.press) begin
        time_nxt = tok_i.now;
        int_nxt  = 1'b0;
        held_nxt = 1'b1;
      end else begin
        tok_nxt.do_tap = ~tok_i.lsw & ~int_scan & (elapsed < tap_window);
        held_nxt       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
      time_r  <= '0;
      int_r   <= 1'b0;
      held_r  <= 1'b0;
      tok_r   <= '0;
    end else begin
      if (entry_we) begin
        entry_r <= entry_wdata;
      end
      time_r <= time_nxt;
      int_r  <= int_nxt;
      held_r <= held_nxt;
      tok_r  <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

// ----- hw/rtl/phmt_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phmt_checker
// Port-level checks of the key engine, bound to the top level.
// ----------------------------------------------------------------------------
module phmt_checker
  import phmt_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_action,
  input logic        out_handled,
  input logic        out_last
);

  // a non-final result is always followed by the tap
  a_tap_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid && out_action == ACT_TAP)
    else $error("second result missing after non-final transfer");

  a_none_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == ACT_NONE |-> out_last && !out_handled)
    else $error("no-action result must be final and unhandled");

  a_reg_tap_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action == ACT_REGISTER || out_action == ACT_TAP)
      |-> out_last && out_handled)
    else $error("register or tap result must be final and handled");

  // one item in flight
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

endmodule

bind pre_hold_mod_tap_engine_top phmt_checker u_phmt_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_action  (out_ch.action),
  .out_handled (out_ch.handled),
  .out_last    (out_ch.last)
);

// ----- tb/sv/phmt_tb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phmt_tb_pkg
// Item opcodes and spare register indexes used by the testbench.
// ----------------------------------------------------------------------------
package phmt_tb_pkg;

  localparam logic OP_KEY   = 1'b0;
  localparam logic OP_LAYER = 1'b1;

  // Register indexes with no register behind them; writes must be dropped
  localparam logic [2:0] REG_SPARE_SIX   = 3'd6;
  localparam logic [2:0] REG_SPARE_SEVEN = 3'd7;

endpackage

// ----- tb/sv/phmt_tap_hold_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phmt_tap_hold_checker
// Watches the register, event and result channels of the dual-role key
// engine, keeps its own copy of the entry table and hold state, predicts the
// register/unregister/tap actions of each event and compares every result.
// ----------------------------------------------------------------------------
module phmt_tap_hold_checker
  import phmt_pkg::*;
  import phmt_tb_pkg::*;
#(
  parameter int N_ENTRIES = 5
) (
  input  logic clk,
  input  logic rst_n,
  phmt_in_if   in_ch,
  phmt_out_if  out_ch,
  phmt_cfg_if  cfg_ch,
  output int   n_fail,
  output int   n_pending
);

  typedef struct {
    action_e     act;
    logic [15:0] code;
    logic        handled;
    logic        last;
  } key_action_t;

  key_action_t        expected_actions[$];
  logic [TIME_W-1:0]  win;
  logic [ENTRY_W-1:0] entry_tab [MAX_SLOTS];
  logic [TIME_W-1:0]  press_t   [MAX_SLOTS];
  logic               intr      [MAX_SLOTS];
  logic               held      [MAX_SLOTS];
  logic               lsw;
  logic [LAYER_W-1:0] prev_layer;
  int                 fails;

  task automatic add_action(action_e a, logic [15:0] c, logic h, logic l);
    key_action_t x;
    x.act     = a;
    x.code    = c;
    x.handled = h;
    x.last    = l;
    expected_actions.push_back(x);
  endtask

  task automatic write_cfg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
    case (idx)
      REG_TAP_WINDOW: begin
        win = val[TIME_W-1:0];
      end
      REG_ENTRY_ZERO, REG_ENTRY_ONE, REG_ENTRY_TWO, REG_ENTRY_THREE,
      REG_ENTRY_FOUR: begin
        entry_tab[idx - REG_ENTRY_ZERO] = val;
      end
      default: ;
    endcase
  endtask

  task automatic predict_actions(logic op, logic [KEY_W-1:0] key, logic press,
                                 logic [TIME_W-1:0] now, logic [LAYER_W-1:0] lay);
    int                hit;
    logic [TIME_W-1:0] age;
    logic [KEY_W-1:0]  mod_c;
    logic [KEY_W-1:0]  tap_c;
    hit = -1;
    if (op == OP_LAYER) begin
      lsw = (lay != prev_layer);
      prev_layer = lay;
      add_action(ACT_NONE, '0, 1'b0, 1'b1);
    end else begin
      // any press, or a hold past the window, interrupts every held entry
      for (int i = 0; i < N_ENTRIES; i++) begin
        age = now - press_t[i];
        if (held[i] && (press || age > win)) intr[i] = 1'b1;
      end
      // scan downward so the lowest matching entry wins
      for (int i = N_ENTRIES - 1; i >= 0; i--) begin
        if (entry_tab[i][47:32] != '0 && entry_tab[i][47:32] == key) hit = i;
      end
      if (hit < 0) begin
        add_action(ACT_NONE, '0, 1'b0, 1'b1);
      end else begin
        mod_c = entry_tab[hit][31:16];
        tap_c = entry_tab[hit][15:0];
        age   = now - press_t[hit];
        if (press) begin
          press_t[hit] = now;
          intr[hit]    = 1'b0;
          held[hit]    = 1'b1;
          add_action(ACT_REGISTER, mod_c, 1'b1, 1'b1);
        end else begin
          if (!lsw && !intr[hit] && age < win) begin
            add_action(ACT_UNREGISTER, mod_c, 1'b1, 1'b0);
            add_action(ACT_TAP, tap_c, 1'b1, 1'b1);
          end else begin
            add_action(ACT_UNREGISTER, mod_c, 1'b1, 1'b1);
          end
          held[hit] = 1'b0;
        end
      end
      lsw = 1'b0;
    end
  endtask

  task automatic check_result();
    key_action_t want;
    if (expected_actions.size() == 0) begin
      fails++;
      $display("%0t: unexpected result: action %0d code %h handled %b last %b",
               $time, out_ch.action, out_ch.code, out_ch.handled, out_ch.last);
    end else begin
      want = expected_actions.pop_front();
      if (out_ch.action !== want.act || out_ch.code !== want.code ||
          out_ch.handled !== want.handled || out_ch.last !== want.last) begin
        fails++;
        $display("%0t: result mismatch: expected action %0d code %h handled %b last %b,",
                 $time, want.act, want.code, want.handled, want.last,
                 " got action %0d code %h handled %b last %b",
                 out_ch.action, out_ch.code, out_ch.handled, out_ch.last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      win        = TAP_WINDOW_RST;
      lsw        = 1'b0;
      prev_layer = '0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
        entry_tab[i] = '0;
        press_t[i]   = '0;
        intr[i]      = 1'b0;
        held[i]      = 1'b0;
      end
      expected_actions.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) write_cfg(cfg_ch.addr, cfg_ch.data);
      if (in_ch.valid && in_ch.ready) begin
        predict_actions(in_ch.op, in_ch.keycode, in_ch.pressed, in_ch.now_ms,
                        in_ch.layer_state);
      end
      if (out_ch.valid && out_ch.ready) check_result();
    end
    n_fail    <= fails;
    n_pending <= expected_actions.size();
  end

endmodule

// ----- tb/sv/pre_hold_mod_tap_engine_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pre_hold_mod_tap_engine_top_tb
// Drives the dual-role key engine with directed tap/hold cases, then with
// random press/release sequences over several table settings, under random
// sender bursts and receiver stalls; the checker judges every result.
// ----------------------------------------------------------------------------
module pre_hold_mod_tap_engine_top_tb;
  import phmt_pkg::*;
  import phmt_tb_pkg::*;

  localparam int N_ENTRIES   = 5;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_LEN    = 400;
  localparam int N_PHASES    = 6;
  localparam int PHASE_ITEMS = 192;

  logic        clk;
  logic        rst_n;
  int          n_fail;
  int          n_pending;
  int          cycle_cnt;
  int          sent;
  int          burst_left;
  int          gap_max;
  int          hold_req;
  int          hold_done;
  logic [15:0] clock_ms;
  logic [15:0] win_copy;
  logic [15:0] trig_copy [MAX_SLOTS];
  logic [31:0] layer_copy;

  phmt_in_if  in_ch ();
  phmt_out_if out_ch ();
  phmt_cfg_if cfg_ch ();

  pre_hold_mod_tap_engine_top #(.NUM_ENTRIES(N_ENTRIES)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  phmt_tap_hold_checker #(.N_ENTRIES(N_ENTRIES)) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_ch    (cfg_ch),
    .n_fail    (n_fail),
    .n_pending (n_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: random stall patterns, plus long hold-offs on request
  initial begin
    int mode;
    int seg;
    out_ch.ready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_done != hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        hold_done++;
      end else begin
        mode = $urandom_range(0, 3);
        seg  = $urandom_range(10, 150);
        while (seg > 0 && hold_done == hold_req) begin
          case (mode)
            0:       out_ch.ready <= 1'b1;
            1:       out_ch.ready <= 1'($urandom);
            2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
            default: out_ch.ready <= (seg % 3 != 0);
          endcase
          @(posedge clk);
          seg--;
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [47:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_TAP_WINDOW) win_copy = val[15:0];
    else if (idx >= REG_ENTRY_ZERO && idx <= REG_ENTRY_FOUR)
      trig_copy[idx - REG_ENTRY_ZERO] = val[47:32];
  endtask

  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic offer(logic op, logic [15:0] key, logic press, logic [15:0] now,
                       logic [31:0] lay);
    pace();
    in_ch.valid       <= 1'b1;
    in_ch.op          <= op;
    in_ch.keycode     <= key;
    in_ch.pressed     <= press;
    in_ch.now_ms      <= now;
    in_ch.layer_state <= lay;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
  endtask

  task automatic key_ev(logic [15:0] key, logic press, logic [15:0] now);
    offer(OP_KEY, key, press, now, 32'($urandom));
  endtask

  task automatic layer_ev(logic [31:0] mask);
    offer(OP_LAYER, 16'($urandom), 1'($urandom), 16'($urandom), mask);
    layer_copy = mask;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_phase(int ph);
    logic [15:0] pool [3];
    logic [47:0] ent;
    logic [15:0] w;
    for (int k = 0; k < 3; k++) pool[k] = 16'($urandom_range(1, 16'hFFFF));
    case (ph)
      0:       w = TAP_WINDOW_RST;
      1:       w = 16'h0000;
      2:       w = 16'hFFFF;
      3:       w = 16'h0001;
      4:       w = 16'($urandom_range(20, 600));
      default: w = 16'($urandom);
    endcase
    // upper data bits are junk and must be masked off
    write_reg(REG_TAP_WINDOW, {32'($urandom), w});
    for (int e = 0; e < N_ENTRIES; e++) begin
      case ($urandom_range(0, 5))
        0:       ent[47:32] = 16'h0000;
        1:       ent[47:32] = 16'hFFFF;
        2:       ent[47:32] = 16'($urandom);
        default: ent[47:32] = pool[$urandom_range(0, 2)];
      endcase
      case ($urandom_range(0, 7))
        0:       ent[31:0] = 32'h0000_0000;
        1:       ent[31:0] = 32'hFFFF_FFFF;
        default: ent[31:0] = 32'($urandom);
      endcase
      write_reg(3'(int'(REG_ENTRY_ZERO) + e), ent);
    end
    if (ph % 2 == 1) begin
      write_reg(REG_SPARE_SIX, {16'($urandom), 32'($urandom)});
      write_reg(REG_SPARE_SEVEN, {16'($urandom), 32'($urandom)});
    end
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [15:0] hold_delta();
    case ($urandom_range(0, 9))
      6:       return win_copy;
      7:       return win_copy + 16'd1;
      8:       return win_copy - 16'd1;
      9:       return 16'($urandom);
      default: return (win_copy == '0) ? 16'd0 : 16'($urandom_range(0, win_copy - 1));
    endcase
  endfunction

  task automatic noise_item();
    logic [15:0] key;
    case ($urandom_range(0, 7))
      0:       key = 16'h0000;
      1, 2:    key = trig_copy[$urandom_range(0, N_ENTRIES - 1)];
      default: key = 16'($urandom);
    endcase
    if ($urandom_range(0, 3) == 0) layer_ev(32'($urandom));
    else key_ev(key, 1'($urandom), 16'($urandom));
  endtask

  task automatic side_event();
    clock_ms += 16'($urandom_range(0, 20));
    case ($urandom_range(0, 4))
      0:       layer_ev(layer_copy);
      1:       layer_ev(32'($urandom));
      2:       key_ev(trig_copy[$urandom_range(0, N_ENTRIES - 1)], 1'($urandom), clock_ms);
      3:       key_ev(16'($urandom), 1'b0, clock_ms);
      default: key_ev(16'($urandom), 1'b1, clock_ms);
    endcase
  endtask

  // press a trigger, maybe something in between, release after a chosen hold
  task automatic tap_sequence();
    int e;
    int extra;
    e = $urandom_range(0, N_ENTRIES - 1);
    if (trig_copy[e] == '0) begin
      noise_item();
    end else begin
      key_ev(trig_copy[e], 1'b1, clock_ms);
      extra = $urandom_range(0, 3);
      if (extra >= 2) repeat (extra - 1) side_event();
      clock_ms += hold_delta();
      key_ev(trig_copy[e], 1'b0, clock_ms);
    end
  endtask

  initial begin
    int target;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.op          = OP_KEY;
    in_ch.keycode     = '0;
    in_ch.pressed     = 1'b0;
    in_ch.now_ms      = '0;
    in_ch.layer_state = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.addr       = REG_TAP_WINDOW;
    cfg_ch.data       = '0;
    win_copy          = TAP_WINDOW_RST;
    layer_copy        = '0;
    for (int i = 0; i < MAX_SLOTS; i++) trig_copy[i] = '0;
    gap_max = 3;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table: nothing may match
    key_ev(16'h0000, 1'b1, 16'd100);
    layer_ev(32'hFFFF_FFFF);
    drain();

    // duplicate trigger in entry three is shadowed; entry four has trigger zero
    write_reg(REG_ENTRY_ZERO,  {16'h0004, 16'h00E0, 16'h0029});
    write_reg(REG_ENTRY_ONE,   {16'hFFFF, 16'hFFFF, 16'hFFFF});
    write_reg(REG_ENTRY_TWO,   {16'h0001, 16'h0000, 16'h0000});
    write_reg(REG_ENTRY_THREE, {16'h0004, 16'h1234, 16'h5678});
    write_reg(REG_ENTRY_FOUR,  {16'h0000, 16'hABCD, 16'hEF01});
    cfg_ch.valid <= 1'b0;

    key_ev(16'h0000, 1'b1, 16'd200);
    key_ev(16'h0000, 1'b0, 16'd201);
    key_ev(16'h0004, 1'b1, 16'd1000);
    key_ev(16'h0004, 1'b0, 16'd1010);   // short: unregister then tap
    key_ev(16'hFFFF, 1'b1, 16'd2000);
    key_ev(16'hFFFF, 1'b0, 16'd2150);   // exactly the window: no tap
    key_ev(16'hFFFF, 1'b1, 16'd3000);
    key_ev(16'hFFFF, 1'b0, 16'd3151);   // past the window
    key_ev(16'h0004, 1'b1, 16'd4000);
    key_ev(16'h0001, 1'b1, 16'd4005);   // interrupts the held entry
    key_ev(16'h0001, 1'b0, 16'd4006);
    key_ev(16'h0004, 1'b0, 16'd4010);
    key_ev(16'h0004, 1'b1, 16'd5000);
    layer_ev(32'd5);                    // layer change kills the tap
    key_ev(16'h0004, 1'b0, 16'd5010);
    key_ev(16'h0004, 1'b1, 16'd6000);
    layer_ev(32'd5);                    // same mask: tap survives
    key_ev(16'h0004, 1'b0, 16'd6010);
    key_ev(16'h0004, 1'b1, 16'd65530);
    key_ev(16'h0004, 1'b0, 16'd4);      // time wraps
    layer_ev(32'd0);
    key_ev(16'h1234, 1'b0, 16'd7000);
    key_ev(16'hFFFF, 1'b0, 16'd7000);   // release of an entry not held

    clock_ms = 16'($urandom);
    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain();
      load_phase(ph);
      gap_max = (ph == 2) ? 0 : ((ph == 5) ? 40 : 12);
      if (ph == 1 || ph == 4) hold_req++;
      target = sent + PHASE_ITEMS;
      while (sent < target) begin
        if ($urandom_range(0, 3) != 0) tap_sequence();
        else noise_item();
      end
    end
    drain();
    repeat (20) @(posedge clk);

    if (n_fail == 0 && n_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
